[rtl/sacl_pkg.sv]
// ----------------------------------------------------------------------------
// sacl_pkg
// Shared types and constants of the set-associative cache tag store.
// ----------------------------------------------------------------------------
package sacl_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_POLICY      = 2'd3;

    localparam logic [4:0] RST_OFFSET_BITS = 5'd2;
    localparam logic [3:0] RST_SET_BITS    = 4'd0;
    localparam logic [3:0] RST_WAYS_IN_USE = 4'd1;

    localparam logic POLICY_LRU  = 1'b0;
    localparam logic POLICY_FIFO = 1'b1;

    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // masked set value before reduction: up to 15 set bits
    localparam int SETV_W = 15;
    // compare width for the way count (register value and way limit)
    localparam int WAYS_CMP_W = 5;

    localparam int CNT_W = 32;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_LOOK
    } t_state;

endpackage

[rtl/set_assoc_cache_lru_fifo_unit.sv]
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_fifo_unit
// Tag store of a set-associative cache with LRU or FIFO replacement.
//
// Input channel (i_valid/o_ready) takes one access: i_cmd (0 read, 1 write)
// and i_address. Output channel (o_valid/i_ready) returns one item per access:
// hit flag and the running read, write, hit and miss counts, all wrapping at
// 32 bits. Configuration (i_cfg_we, i_cfg_index, i_cfg_data) is a plain write
// port; the user writes it only while no access is in flight (not enforced).
//
// Each set is one row of two RAMs (tags, and valid bits with age ranks).
// An access reads its set row, then matches, updates and writes it back; the
// next access is taken only after that single read-modify-write of the row.
// When MAX_SETS is a power of two, the row is read at acceptance; otherwise
// the set index is first reduced by a registered reciprocal multiply.
//
// Reset clears the configuration to its defaults, the counters, and the
// per-set row-valid flops; all lines read as invalid after reset, with no
// clearing pass. A result that the receiver stalls sits in the output
// register; the next access is accepted meanwhile and waits in ST_LOOK for it.
// ----------------------------------------------------------------------------
module set_assoc_cache_lru_fifo_unit
    import sacl_pkg::*;
#(
    parameter int MAX_SETS  = 256,
    parameter int MAX_WAYS  = 8,
    parameter int ADDR_BITS = 48
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // access items
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_cmd,
    input  logic [ADDR_BITS-1:0]  i_address,
    // result items
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic                  o_hit,
    output logic [CNT_W-1:0]      o_read_count,
    output logic [CNT_W-1:0]      o_write_count,
    output logic [CNT_W-1:0]      o_hit_count,
    output logic [CNT_W-1:0]      o_miss_count
);

    localparam int SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int ORD_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int META_W = MAX_WAYS * (ORD_W + 1);
    localparam int TROW_W = MAX_WAYS * ADDR_BITS;

    // configuration registers
    logic [4:0] r_cfg_off;
    logic [3:0] r_cfg_set;
    logic [3:0] r_cfg_ways;
    logic       r_cfg_pol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_off  <= RST_OFFSET_BITS;
            r_cfg_set  <= RST_SET_BITS;
            r_cfg_ways <= RST_WAYS_IN_USE;
            r_cfg_pol  <= POLICY_LRU;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_OFFSET_BITS: r_cfg_off  <= i_cfg_data[4:0];
                CFG_SET_BITS:    r_cfg_set  <= i_cfg_data[3:0];
                CFG_WAYS_IN_USE: r_cfg_ways <= i_cfg_data[3:0];
                CFG_POLICY:      r_cfg_pol  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // address split
    logic [5:0]           tag_shift;
    logic [ADDR_BITS-1:0] in_tag;
    logic [ADDR_BITS-1:0] in_blk;
    logic [SETV_W-1:0]    set_mask;
    logic [SETV_W-1:0]    set_value;

    assign tag_shift = {1'b0, r_cfg_off} + {2'b00, r_cfg_set};
    assign in_tag    = i_address >> tag_shift;
    assign in_blk    = i_address >> r_cfg_off;
    assign set_mask  = ~({SETV_W{1'b1}} << r_cfg_set);
    assign set_value = in_blk[SETV_W-1:0] & set_mask;

    // control
    t_state r_state;
    t_state n_state;
    logic   red_start;
    logic   red_done;
    logic   rd_en;
    logic   commit;
    logic   out_free;

    logic [SET_W-1:0] red_index;

    sacl_set_reduce #(
        .NUM_SETS (MAX_SETS)
    ) u_set_reduce (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (red_start),
        .i_value (set_value),
        .o_done  (red_done),
        .o_index (red_index)
    );

    logic r_out_valid;
    assign out_free = !r_out_valid || i_ready;

    always_comb begin
        n_state   = r_state;
        o_ready   = 1'b0;
        red_start = 1'b0;
        rd_en     = 1'b0;
        commit    = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    red_start = 1'b1;
                    if (red_done) begin
                        rd_en   = 1'b1;
                        n_state = ST_LOOK;
                    end else begin
                        n_state = ST_REDUCE;
                    end
                end
            end
            ST_REDUCE: begin
                if (red_done) begin
                    rd_en   = 1'b1;
                    n_state = ST_LOOK;
                end
            end
            ST_LOOK: begin
                if (out_free) begin
                    commit  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // item registers
    logic [ADDR_BITS-1:0] r_tag;
    logic                 r_cmd;
    logic [SET_W-1:0]     r_idx;

    always_ff @(posedge i_clk) begin
        if (red_start) begin
            r_tag <= in_tag;
            r_cmd <= i_cmd;
        end
        if (rd_en) begin
            r_idx <= red_index;
        end
    end

    // set row storage
    logic [TROW_W-1:0] tag_rdata;
    logic [TROW_W-1:0] tag_wdata;
    logic [META_W-1:0] meta_rdata;
    logic [META_W-1:0] meta_seen;
    logic [META_W-1:0] meta_wdata;
    logic              tag_we;
    logic [MAX_SETS-1:0] r_row_vld;

    sacl_ram #(
        .WIDTH (TROW_W),
        .DEPTH (MAX_SETS)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (tag_we),
        .i_waddr (r_idx),
        .i_wdata (tag_wdata),
        .i_re    (rd_en),
        .i_raddr (red_index),
        .o_rdata (tag_rdata)
    );

    sacl_ram #(
        .WIDTH (META_W),
        .DEPTH (MAX_SETS)
    ) u_meta_ram (
        .i_clk   (i_clk),
        .i_we    (commit),
        .i_waddr (r_idx),
        .i_wdata (meta_wdata),
        .i_re    (rd_en),
        .i_raddr (red_index),
        .o_rdata (meta_rdata)
    );

    // a row never written since reset reads as all invalid, rank zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
        end else if (commit) begin
            r_row_vld[r_idx] <= 1'b1;
        end
    end

    assign meta_seen = r_row_vld[r_idx] ? meta_rdata : '0;

    logic                lk_hit;
    logic [MAX_WAYS-1:0] fill_oh;

    sacl_ways #(
        .MAX_WAYS  (MAX_WAYS),
        .ADDR_BITS (ADDR_BITS)
    ) u_ways (
        .i_tag_row  (tag_rdata),
        .i_meta_row (meta_seen),
        .i_tag      (r_tag),
        .i_ways     (r_cfg_ways),
        .i_policy   (r_cfg_pol),
        .o_hit      (lk_hit),
        .o_fill_oh  (fill_oh),
        .o_meta_row (meta_wdata)
    );

    always_comb begin
        for (int w = 0; w < MAX_WAYS; w++) begin
            tag_wdata[w*ADDR_BITS +: ADDR_BITS] =
                fill_oh[w] ? r_tag : tag_rdata[w*ADDR_BITS +: ADDR_BITS];
        end
    end

    assign tag_we = commit && !lk_hit;

    // counters double as the output payload: they only move on a commit,
    // which needs the output register free or draining
    logic [CNT_W-1:0] r_reads;
    logic [CNT_W-1:0] r_writes;
    logic [CNT_W-1:0] r_hits;
    logic [CNT_W-1:0] r_misses;
    logic             r_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reads     <= '0;
            r_writes    <= '0;
            r_hits      <= '0;
            r_misses    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (commit) begin
                r_out_valid <= 1'b1;
                if (lk_hit) begin
                    r_hits <= r_hits + 1'b1;
                end else begin
                    r_reads  <= r_reads + 1'b1;
                    r_misses <= r_misses + 1'b1;
                end
                if (r_cmd == CMD_WRITE) begin
                    r_writes <= r_writes + 1'b1;
                end
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_hit <= lk_hit;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_hit         = r_hit;
    assign o_read_count  = r_reads;
    assign o_write_count = r_writes;
    assign o_hit_count   = r_hits;
    assign o_miss_count  = r_misses;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_reads_track_misses: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_reads == r_misses)
        else $error("read count diverged from miss count");

    a_one_count_per_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit |=> CNT_W'(r_hits + r_misses) == CNT_W'($past(r_hits + r_misses) + 1'b1))
        else $error("hit plus miss count did not advance by one");

    a_miss_fills_one_way: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (commit && !lk_hit) |-> $onehot(fill_oh))
        else $error("miss did not select exactly one way");

    a_hit_fills_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (commit && lk_hit) |-> (fill_oh == '0))
        else $error("hit replaced a way");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("second item accepted while one is in flight");

endmodule

[rtl/sacl_ram.sv]
// ----------------------------------------------------------------------------
// sacl_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module sacl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                    i_wdata,
    input  logic                                i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                    o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // read data holds until the next read
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/sacl_set_reduce.sv]
// ----------------------------------------------------------------------------
// sacl_set_reduce
// Reduces the masked set value modulo the number of physical sets.
// Power-of-two set counts take the low bits at once; other counts take the
// remainder through a reciprocal multiply, registering quotient then remainder.
// ----------------------------------------------------------------------------
module sacl_set_reduce
    import sacl_pkg::*;
#(
    parameter int NUM_SETS = 256
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [SETV_W-1:0]      i_value,
    output logic                   o_done,
    output logic [(NUM_SETS > 1 ? $clog2(NUM_SETS) : 1)-1:0] o_index
);

    localparam int SET_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam bit IS_POW2 = ((NUM_SETS & (NUM_SETS - 1)) == 0);

    generate
        if (IS_POW2) begin : g_pow2
            assign o_done = i_start;
            if (NUM_SETS > 1) begin : g_bits
                assign o_index = i_value[SET_W-1:0];
            end else begin : g_single
                assign o_index = '0;
            end
        end else begin : g_iter
            // (v * RCP_M) >> RCP_K is the exact quotient for every SETV_W-bit v
            localparam int     RCP_K  = SETV_W + SET_W;
            localparam int     RCP_W  = 17;
            localparam int     PROD_W = SETV_W + RCP_W;
            localparam longint RCP_M  =
                ((longint'(1) << RCP_K) + longint'(NUM_SETS) - longint'(1))
                / longint'(NUM_SETS);

            logic              r_busy;
            logic              r_done;
            logic [SETV_W-1:0] r_val;
            logic [SETV_W-1:0] r_quo;
            logic [SETV_W-1:0] r_rem;
            logic [PROD_W-1:0] prod;
            logic [SETV_W-1:0] quo_mul;

            assign prod    = PROD_W'(i_value) * PROD_W'(RCP_M);
            // quotient times set count never exceeds the value, so no bits are lost
            assign quo_mul = r_quo * SETV_W'(NUM_SETS);

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b0;
                end else begin
                    r_busy <= i_start;
                    r_done <= r_busy;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_start) begin
                    r_val <= i_value;
                    r_quo <= SETV_W'(prod >> RCP_K);
                end
                if (r_busy) begin
                    r_rem <= r_val - quo_mul;
                end
            end

            assign o_done  = r_done;
            assign o_index = r_rem[SET_W-1:0];
        end
    endgenerate

endmodule

[rtl/sacl_ways.sv]
// ----------------------------------------------------------------------------
// sacl_ways
// Lookup and replacement logic for one set: tag match, fill or victim
// choice, and the age-rank update written back to the metadata row.
// ----------------------------------------------------------------------------
module sacl_ways
    import sacl_pkg::*;
#(
    parameter int MAX_WAYS  = 8,
    parameter int ADDR_BITS = 48
) (
    input  logic [MAX_WAYS*ADDR_BITS-1:0]   i_tag_row,
    input  logic [MAX_WAYS*((MAX_WAYS > 1 ? $clog2(MAX_WAYS) : 1)+1)-1:0] i_meta_row,
    input  logic [ADDR_BITS-1:0]            i_tag,
    input  logic [3:0]                      i_ways,
    input  logic                            i_policy,
    output logic                            o_hit,
    output logic [MAX_WAYS-1:0]             o_fill_oh,
    output logic [MAX_WAYS*((MAX_WAYS > 1 ? $clog2(MAX_WAYS) : 1)+1)-1:0] o_meta_row
);

    localparam int ORD_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WAY_W = ORD_W;
    localparam int OFS_V = MAX_WAYS * ORD_W;
    localparam logic [ORD_W:0] RANK_SAT = (ORD_W+1)'(MAX_WAYS - 1);
    localparam logic [ORD_W:0] RANK_NEW = (ORD_W+1)'(MAX_WAYS);

    logic [ORD_W-1:0]      ord     [MAX_WAYS];
    logic [ORD_W-1:0]      new_ord [MAX_WAYS];
    logic [ADDR_BITS-1:0]  tagv    [MAX_WAYS];
    logic [MAX_WAYS-1:0]   vld;
    logic [MAX_WAYS-1:0]   in_use;
    logic [WAYS_CMP_W-1:0] ways_eff;

    logic             hit_found;
    logic [WAY_W-1:0] hit_way;
    logic             inv_found;
    logic [WAY_W-1:0] inv_way;
    logic [WAY_W-1:0] vic_way;
    logic [ORD_W-1:0] vic_ord;
    logic [WAY_W-1:0] tgt_way;
    logic             tgt_was_vld;
    logic             do_touch;
    logic [ORD_W:0]   old_rank;

    always_comb begin
        if (i_ways == '0) begin
            ways_eff = WAYS_CMP_W'(1);
        end else if (WAYS_CMP_W'(i_ways) > WAYS_CMP_W'(MAX_WAYS)) begin
            ways_eff = WAYS_CMP_W'(MAX_WAYS);
        end else begin
            ways_eff = WAYS_CMP_W'(i_ways);
        end

        for (int w = 0; w < MAX_WAYS; w++) begin
            vld[w]    = i_meta_row[OFS_V + w];
            ord[w]    = i_meta_row[w*ORD_W +: ORD_W];
            tagv[w]   = i_tag_row[w*ADDR_BITS +: ADDR_BITS];
            in_use[w] = (WAYS_CMP_W'(w) < ways_eff);
        end

        // first matching way, first free way
        hit_found = 1'b0;
        hit_way   = '0;
        inv_found = 1'b0;
        inv_way   = '0;
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (!hit_found && in_use[w] && vld[w] && tagv[w] == i_tag) begin
                hit_found = 1'b1;
                hit_way   = WAY_W'(w);
            end
            if (!inv_found && in_use[w] && !vld[w]) begin
                inv_found = 1'b1;
                inv_way   = WAY_W'(w);
            end
        end

        // oldest way, ties to the lowest index
        vic_way = '0;
        vic_ord = ord[0];
        for (int w = 1; w < MAX_WAYS; w++) begin
            if (in_use[w] && ord[w] > vic_ord) begin
                vic_way = WAY_W'(w);
                vic_ord = ord[w];
            end
        end

        if (hit_found) begin
            tgt_way     = hit_way;
            tgt_was_vld = 1'b1;
            do_touch    = (i_policy == POLICY_LRU);
        end else if (inv_found) begin
            tgt_way     = inv_way;
            tgt_was_vld = 1'b0;
            do_touch    = 1'b1;
        end else begin
            tgt_way     = vic_way;
            tgt_was_vld = 1'b1;
            do_touch    = 1'b1;
        end

        // a fresh fill ranks older than every way
        old_rank = tgt_was_vld ? {1'b0, ord[tgt_way]} : RANK_NEW;

        for (int w = 0; w < MAX_WAYS; w++) begin
            new_ord[w]   = ord[w];
            o_fill_oh[w] = !hit_found && (WAY_W'(w) == tgt_way);
            if (do_touch) begin
                if (WAY_W'(w) == tgt_way) begin
                    new_ord[w] = '0;
                end else if (in_use[w] && vld[w] && {1'b0, ord[w]} < old_rank
                             && {1'b0, ord[w]} < RANK_SAT) begin
                    new_ord[w] = ord[w] + 1'b1;
                end
            end
        end

        for (int w = 0; w < MAX_WAYS; w++) begin
            o_meta_row[w*ORD_W +: ORD_W] = new_ord[w];
            o_meta_row[OFS_V + w]        = vld[w] | o_fill_oh[w];
        end

        o_hit = hit_found;
    end

endmodule

[verif/set_assoc_cache_lru_fifo_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_fifo_unit_tb
// Self-checking bench for the cache tag store with LRU / FIFO replacement.
// Accesses go in over valid/ready with bursty gaps while the result side
// stalls on its own pattern. Each accepted item is run through a local tag
// store model and the hit flag and the four running counts are compared
// field by field. The geometry and the policy are swept between phases,
// including out-of-range register values.
// ----------------------------------------------------------------------------
module set_assoc_cache_lru_fifo_unit_tb;
    import sacl_pkg::*;

    localparam int MAX_SETS    = 256;
    localparam int MAX_WAYS    = 8;
    localparam int ADDR_BITS   = 48;
    localparam int TAG_POOL_N  = 12;
    localparam int DRAIN_LIMIT = 5000;

    typedef struct packed {
        logic             hit;
        logic [CNT_W-1:0] reads;
        logic [CNT_W-1:0] writes;
        logic [CNT_W-1:0] hits;
        logic [CNT_W-1:0] misses;
    } t_access_outcome;

    typedef enum int {
        RX_ALWAYS,
        RX_RANDOM,
        RX_PERIODIC
    } t_rx_mode;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_valid;
    logic                  o_ready;
    logic                  i_cmd;
    logic [ADDR_BITS-1:0]  i_address;
    logic                  o_valid;
    logic                  i_ready;
    logic                  o_hit;
    logic [CNT_W-1:0]      o_read_count;
    logic [CNT_W-1:0]      o_write_count;
    logic [CNT_W-1:0]      o_hit_count;
    logic [CNT_W-1:0]      o_miss_count;

    // local copy of the tag store and its configuration
    logic [4:0]           cfg_offset_bits;
    logic [3:0]           cfg_set_bits;
    logic [3:0]           cfg_ways_in_use;
    logic                 cfg_policy;
    logic [ADDR_BITS-1:0] line_tag   [MAX_SETS][MAX_WAYS];
    bit                   line_valid [MAX_SETS][MAX_WAYS];
    logic [2:0]           line_order [MAX_SETS][MAX_WAYS];
    logic [CNT_W-1:0]     reads_total;
    logic [CNT_W-1:0]     writes_total;
    logic [CNT_W-1:0]     hits_total;
    logic [CNT_W-1:0]     misses_total;

    t_access_outcome      access_outcomes[$];
    int                   mismatch_count;

    t_rx_mode             rx_mode;
    int                   rx_hold_cycles;
    int                   rx_cycle;

    logic [ADDR_BITS-1:0] tag_pool[TAG_POOL_N];
    int                   tag_pool_used;

    set_assoc_cache_lru_fifo_unit #(
        .MAX_SETS  (MAX_SETS),
        .MAX_WAYS  (MAX_WAYS),
        .ADDR_BITS (ADDR_BITS)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_cmd         (i_cmd),
        .i_address     (i_address),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_hit         (o_hit),
        .o_read_count  (o_read_count),
        .o_write_count (o_write_count),
        .o_hit_count   (o_hit_count),
        .o_miss_count  (o_miss_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // ------------------------------------------------------------------
    // tag store model
    // ------------------------------------------------------------------
    task automatic reset_tag_store();
        cfg_offset_bits = RST_OFFSET_BITS;
        cfg_set_bits    = RST_SET_BITS;
        cfg_ways_in_use = RST_WAYS_IN_USE;
        cfg_policy      = POLICY_LRU;
        for (int s = 0; s < MAX_SETS; s++) begin
            for (int w = 0; w < MAX_WAYS; w++) begin
                line_tag[s][w]   = '0;
                line_valid[s][w] = 1'b0;
                line_order[s][w] = '0;
            end
        end
        reads_total  = '0;
        writes_total = '0;
        hits_total   = '0;
        misses_total = '0;
    endtask

    // way w becomes newest; newer valid ways age by one, saturating
    task automatic age_ways(input int s, input int w, input int ways, input bit was_valid);
        int old_rank;
        old_rank = was_valid ? int'(line_order[s][w]) : MAX_WAYS;
        for (int i = 0; i < ways; i++) begin
            if (i == w || !line_valid[s][i])
                continue;
            if (line_order[s][i] < old_rank && line_order[s][i] < MAX_WAYS - 1)
                line_order[s][i] = line_order[s][i] + 3'd1;
        end
        line_order[s][w] = '0;
    endtask

    task automatic lookup_tag_store(input logic cmd, input logic [ADDR_BITS-1:0] addr,
                                    output t_access_outcome res);
        int                   ways;
        int                   s;
        int                   w;
        int                   victim;
        logic [ADDR_BITS-1:0] tag;
        logic [ADDR_BITS-1:0] above_offset;
        logic [15:0]          set_mask;
        bit                   hit;
        ways = int'(cfg_ways_in_use);
        if (ways < 1) ways = 1;
        if (ways > MAX_WAYS) ways = MAX_WAYS;
        // shift is at most 46 here, so the tag never collapses to zero
        tag          = addr >> (int'(cfg_offset_bits) + int'(cfg_set_bits));
        above_offset = addr >> cfg_offset_bits;
        set_mask     = (16'd1 << cfg_set_bits) - 16'd1;
        s            = int'(above_offset[15:0] & set_mask) % MAX_SETS;
        hit          = 1'b0;
        for (w = 0; w < ways; w++) begin
            if (line_valid[s][w] && line_tag[s][w] == tag) begin
                hit = 1'b1;
                break;
            end
        end
        if (hit) begin
            hits_total++;
            if (cfg_policy == POLICY_LRU)
                age_ways(s, w, ways, 1'b1);
        end else begin
            misses_total++;
            reads_total++;
            victim = ways;
            for (w = 0; w < ways; w++) begin
                if (!line_valid[s][w]) begin
                    victim = w;
                    break;
                end
            end
            if (victim == ways) begin
                // highest rank goes, ties to the lowest way
                victim = 0;
                for (w = 1; w < ways; w++)
                    if (line_order[s][w] > line_order[s][victim])
                        victim = w;
                age_ways(s, victim, ways, 1'b1);
            end else begin
                age_ways(s, victim, ways, 1'b0);
            end
            line_valid[s][victim] = 1'b1;
            line_tag[s][victim]   = tag;
        end
        if (cmd == CMD_WRITE)
            writes_total++;
        res.hit    = hit;
        res.reads  = reads_total;
        res.writes = writes_total;
        res.hits   = hits_total;
        res.misses = misses_total;
    endtask

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------
    task automatic send_access(input logic cmd, input logic [ADDR_BITS-1:0] addr);
        t_access_outcome outcome;
        i_valid   <= 1'b1;
        i_cmd     <= cmd;
        i_address <= addr;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        lookup_tag_store(cmd, addr, outcome);
        access_outcomes.push_back(outcome);
    endtask

    task automatic idle_sender(input int n);
        i_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic wait_results_drained();
        int guard;
        i_valid <= 1'b0;
        guard = 0;
        while (access_outcomes.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        if (access_outcomes.size() != 0) begin
            $display("%0t: %0d result items never arrived", $time, access_outcomes.size());
            mismatch_count++;
            access_outcomes.delete();
        end
        // leave some margin
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        case (idx)
            CFG_OFFSET_BITS: cfg_offset_bits = data[4:0];
            CFG_SET_BITS:    cfg_set_bits    = data[3:0];
            CFG_WAYS_IN_USE: cfg_ways_in_use = data[3:0];
            CFG_POLICY:      cfg_policy      = data[0];
            default: ;
        endcase
    endtask

    // only called with nothing in flight
    task automatic configure(input logic [4:0] off, input logic [3:0] sets,
                             input logic [3:0] ways, input logic pol);
        write_reg(CFG_OFFSET_BITS, off);
        write_reg(CFG_SET_BITS, CFG_DATA_W'(sets));
        write_reg(CFG_WAYS_IN_USE, CFG_DATA_W'(ways));
        write_reg(CFG_POLICY, CFG_DATA_W'(pol));
        i_cfg_we <= 1'b0;
    endtask

    // mostly tags from a small pool on a few sets, so sets fill and evict
    function automatic logic [ADDR_BITS-1:0] pick_address();
        logic [63:0] wide;
        logic [63:0] setv;
        if ($urandom_range(0, 5) == 0) begin
            wide = {$urandom, $urandom};
        end else begin
            setv = ($urandom_range(0, 3) == 0) ? 64'($urandom) : 64'($urandom_range(0, 3));
            wide = (64'(tag_pool[$urandom_range(0, tag_pool_used - 1)])
                       << (int'(cfg_offset_bits) + int'(cfg_set_bits)))
                 | ((setv & ((64'd1 << cfg_set_bits) - 64'd1)) << cfg_offset_bits)
                 | (64'($urandom) & ((64'd1 << cfg_offset_bits) - 64'd1));
        end
        return wide[ADDR_BITS-1:0];
    endfunction

    // ------------------------------------------------------------------
    // result side: checks each item and drives the stall pattern
    // ------------------------------------------------------------------
    task automatic check_field(input string what, input logic [CNT_W-1:0] want,
                               input logic [CNT_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            mismatch_count++;
        end
    endtask

    task automatic check_outcome();
        t_access_outcome want;
        if (access_outcomes.size() == 0) begin
            $display("%0t: unexpected result item, expected none, actual hit=%0d reads=%0d",
                     $time, o_hit, o_read_count);
            mismatch_count++;
        end else begin
            want = access_outcomes.pop_front();
            check_field("hit", CNT_W'(want.hit), CNT_W'(o_hit));
            check_field("read_count", want.reads, o_read_count);
            check_field("write_count", want.writes, o_write_count);
            check_field("hit_count", want.hits, o_hit_count);
            check_field("miss_count", want.misses, o_miss_count);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            check_outcome();
        rx_cycle = rx_cycle + 1;
        if (rx_hold_cycles > 0) begin
            rx_hold_cycles = rx_hold_cycles - 1;
            i_ready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_ALWAYS: i_ready <= 1'b1;
                RX_RANDOM: i_ready <= ($urandom_range(0, 9) < 7);
                default:   i_ready <= ((rx_cycle % 7) >= 3);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    // one way, one set, 4-byte blocks
    task automatic test_reset_geometry();
        send_access(CMD_READ, 48'h0);
        send_access(CMD_READ, 48'h3);
        send_access(CMD_WRITE, 48'hFFFF_FFFF_FFFF);
        send_access(CMD_WRITE, 48'hFFFF_FFFF_FFFC);
        send_access(CMD_READ, 48'h0);
    endtask

    task automatic test_lru_eviction();
        wait_results_drained();
        configure(5'd4, 4'd2, 4'd4, POLICY_LRU);
        send_access(CMD_READ, 48'h000);
        send_access(CMD_READ, 48'h040);
        send_access(CMD_READ, 48'h080);
        send_access(CMD_READ, 48'h0C0);
        send_access(CMD_READ, 48'h100);
        send_access(CMD_READ, 48'h040);
        send_access(CMD_WRITE, 48'h140);
        send_access(CMD_READ, 48'h010);
    endtask

    // same geometry, lines kept across the policy change
    task automatic test_fifo_eviction();
        wait_results_drained();
        configure(5'd4, 4'd2, 4'd4, POLICY_FIFO);
        send_access(CMD_READ, 48'h080);
        send_access(CMD_WRITE, 48'h180);
        send_access(CMD_READ, 48'h080);
    endtask

    // out-of-range ways, widest offset and set fields, zero ways
    task automatic test_register_extremes();
        wait_results_drained();
        configure(5'd31, 4'd15, 4'd15, POLICY_LRU);
        send_access(CMD_READ, 48'h0);
        send_access(CMD_WRITE, 48'hFFFF_FFFF_FFFF);
        send_access(CMD_READ, 48'h8000_0000_0000);
        send_access(CMD_READ, 48'h7FFF_FFFF_FFFF);
        wait_results_drained();
        configure(5'd0, 4'd8, 4'd0, POLICY_FIFO);
        send_access(CMD_READ, 48'h1FF);
        send_access(CMD_WRITE, 48'h2FF);
        send_access(CMD_READ, 48'h1FF);
    endtask

    task automatic test_random_sweep();
        int          burst;
        bit          gappy;
        logic [63:0] raw;
        for (int phase = 0; phase < 12; phase++) begin
            wait_results_drained();
            case (phase)
                0: configure(5'd0, 4'd0, 4'd8, POLICY_LRU);
                1: configure(5'd16, 4'd8, 4'd8, POLICY_FIFO);
                2: configure(5'd31, 4'd15, 4'd15, POLICY_LRU);
                3: configure(5'd0, 4'd1, 4'd0, POLICY_FIFO);
                4: configure(5'd2, 4'd2, 4'd2, POLICY_LRU);
                default: configure(5'($urandom_range(0, 31)), 4'($urandom_range(0, 15)),
                                   4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
            endcase
            for (int k = 0; k < TAG_POOL_N; k++) begin
                raw = {$urandom, $urandom} >> $urandom_range(0, 63);
                tag_pool[k] = raw[ADDR_BITS-1:0];
            end
            tag_pool_used = $urandom_range(2, TAG_POOL_N);
            rx_mode = t_rx_mode'(phase % 3);
            gappy   = (phase % 2) == 1 || $urandom_range(0, 2) == 0;
            burst   = 0;
            repeat (80) begin
                if (gappy && burst == 0) begin
                    idle_sender($urandom_range(1, 6));
                    burst = $urandom_range(1, 16);
                end
                if (burst > 0)
                    burst--;
                if ($urandom_range(0, 59) == 0)
                    wait_results_drained();
                send_access(1'($urandom_range(0, 1)), pick_address());
            end
        end
    endtask

    // result side holds off long enough for the block to stall its input
    task automatic test_output_backpressure();
        wait_results_drained();
        configure(5'd3, 4'd1, 4'd3, POLICY_LRU);
        tag_pool_used = 6;
        rx_mode        = RX_ALWAYS;
        rx_hold_cycles = 80;
        repeat (40)
            send_access(1'($urandom_range(0, 1)), pick_address());
        wait_results_drained();
        rx_mode = RX_RANDOM;
        repeat (20)
            send_access(1'($urandom_range(0, 1)), pick_address());
    endtask

    initial begin
        mismatch_count = 0;
        rx_mode        = RX_RANDOM;
        rx_hold_cycles = 0;
        rx_cycle       = 0;
        tag_pool_used  = 1;
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        i_valid     <= 1'b0;
        i_cmd       <= CMD_READ;
        i_address   <= '0;
        i_ready     <= 1'b0;
        reset_tag_store();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_geometry();
        test_lru_eviction();
        test_fifo_eviction();
        test_register_extremes();
        test_random_sweep();
        test_output_backpressure();

        wait_results_drained();
        if (mismatch_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
